/* hw/rtl/bfsts_pkg.sv */
// Shared types and constants for the bit-flip sorted table search core.
`default_nettype none
package bfsts_pkg;
  localparam int unsigned NumPosFields = 4;
  localparam int unsigned IndexW = 10;
  localparam int unsigned ValueW = 30;
  localparam int unsigned CountW = 11;
  localparam int unsigned FlipCntW = 3;
  localparam int unsigned PosW = 5;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef struct packed {
    logic                mode;
    logic [IndexW-1:0]   index;
    logic [ValueW-1:0]   entry_value;
    logic [FlipCntW-1:0] flip_count;
    logic [PosW-1:0]     pos_a;
    logic [PosW-1:0]     pos_b;
    logic [PosW-1:0]     pos_c;
    logic [PosW-1:0]     pos_d;
  } req_t;
endpackage
`default_nettype wire

/* hw/rtl/bfsts_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module bfsts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* hw/rtl/bfsts_front.sv */
// Front end: accepts requests and buffers them in a two-entry queue.
`default_nettype none
module bfsts_front import bfsts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  req_t      req_i,
  output logic      full_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output req_t      head_o
);
  req_t       buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue underflow");
endmodule
`default_nettype wire

/* hw/rtl/bfsts_back.sv */
// Back end: table writes, flipped-word fetch and lower-bound binary search.
`default_nettype none
module bfsts_back import bfsts_pkg::*; #(
  parameter int unsigned TableDepth = 1024,
  parameter int unsigned StateBits = 30,
  parameter int unsigned MaxFlips = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              avail_i,
  input  req_t                   req_i,
  output logic                   pop_o,
  output logic                   idle_o,
  input  wire logic [CountW-1:0] entries_used_i,
  output logic                   done_o,
  output logic [CountW-1:0]      found_position_o,
  output logic                   beyond_end_o
);
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned SpanW = $clog2(TableDepth + 1);
  localparam int unsigned FlipLimit = (MaxFlips < NumPosFields) ? MaxFlips : NumPosFields;

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_PROBE, ST_CMP} state_e;

  state_e               state_q;
  logic [StateBits-1:0] word_q;
  logic [SpanW-1:0]     base_q, span_q, half_q;
  logic                 oob_q;
  req_t                 cur_q;

  logic                 ram_we;
  logic [AddrW-1:0]     ram_addr;
  logic [StateBits-1:0] ram_rdata, flipped;
  logic [SpanW-1:0]     n_eff, half_c;
  logic                 idx_ok;

  assign idx_ok = ({{(32-IndexW){1'b0}}, req_i.index} < 32'(TableDepth));
  assign n_eff  = ({{(32-CountW){1'b0}}, entries_used_i} > 32'(TableDepth))
                ? SpanW'(TableDepth) : SpanW'(entries_used_i);
  assign half_c = span_q >> 1;

  assign pop_o  = (state_q == ST_IDLE) && avail_i;
  assign idle_o = (state_q == ST_IDLE);
  assign ram_we = pop_o && (req_i.mode == MODE_WRITE) && idx_ok;

  always_comb begin
    ram_addr = AddrW'(req_i.index);
    if (state_q == ST_PROBE) ram_addr = AddrW'(base_q + half_c);
  end

  bfsts_ram #(.Width(StateBits), .Depth(TableDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (StateBits'(req_i.entry_value)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [PosW-1:0]     p [NumPosFields];
    logic [FlipCntW-1:0] cnt;
    p[0] = cur_q.pos_a;
    p[1] = cur_q.pos_b;
    p[2] = cur_q.pos_c;
    p[3] = cur_q.pos_d;
    cnt = (cur_q.flip_count > FlipCntW'(FlipLimit)) ? FlipCntW'(FlipLimit)
                                                    : cur_q.flip_count;
    flipped = oob_q ? '0 : ram_rdata;
    for (int k = 0; k < NumPosFields; k++) begin
      if ((FlipCntW'(k) < cnt) && ({{(32-PosW){1'b0}}, p[k]} < 32'(StateBits))) begin
        flipped[p[k]] = ~flipped[p[k]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      done_o           <= 1'b0;
      found_position_o <= '0;
      beyond_end_o     <= 1'b0;
      word_q           <= '0;
      base_q           <= '0;
      span_q           <= '0;
      half_q           <= '0;
      oob_q            <= 1'b0;
      cur_q            <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o && req_i.mode == MODE_LOOKUP) begin
            cur_q   <= req_i;
            oob_q   <= !idx_ok;
            base_q  <= '0;
            span_q  <= n_eff;
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          word_q  <= flipped;
          state_q <= ST_PROBE;
        end
        ST_PROBE: begin
          if (span_q == '0) begin
            done_o           <= 1'b1;
            found_position_o <= CountW'(base_q);
            beyond_end_o     <= (base_q >= n_eff);
            state_q          <= ST_IDLE;
          end else begin
            half_q  <= half_c;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (ram_rdata < word_q) begin
            base_q <= base_q + half_q + SpanW'(1);
            span_q <= span_q - half_q - SpanW'(1);
          end else begin
            span_q <= half_q;
          end
          state_q <= ST_PROBE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |=> span_q < $past(span_q))
    else $error("search span did not shrink");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_PROBE)
    else $error("result outside probe state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
endmodule
`default_nettype wire

/* hw/rtl/bit_flip_sorted_table_search_core.sv */
// Top level of the bit-flip sorted table search core.
// A single RAM port serves table writes, the entry fetch and each search probe;
// the engine takes no new request until the current lookup has finished.
// Requests queue two deep ahead of the search engine; busy rises when the
// queue is full. Results appear on done_o for one cycle and cannot be stalled.
`default_nettype none
module bit_flip_sorted_table_search_core import bfsts_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned STATE_BITS = 30,
  parameter int unsigned MAX_FLIPS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                mode_i,
  input  wire logic [IndexW-1:0]   index_i,
  input  wire logic [ValueW-1:0]   entry_value_i,
  input  wire logic [FlipCntW-1:0] flip_count_i,
  input  wire logic [PosW-1:0]     flip_pos_a_i,
  input  wire logic [PosW-1:0]     flip_pos_b_i,
  input  wire logic [PosW-1:0]     flip_pos_c_i,
  input  wire logic [PosW-1:0]     flip_pos_d_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CountW-1:0]   cfg_wdata_i,
  output logic                     done_o,
  output logic [CountW-1:0]        found_position_o,
  output logic                     beyond_end_o
);
  logic [CountW-1:0] entries_used_q;
  req_t req, head;
  logic full, empty, pop, idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) entries_used_q <= CountW'(TABLE_DEPTH);
    else if (cfg_we_i) entries_used_q <= cfg_wdata_i;
  end

  assign req = '{mode: mode_i, index: index_i, entry_value: entry_value_i,
                 flip_count: flip_count_i, pos_a: flip_pos_a_i, pos_b: flip_pos_b_i,
                 pos_c: flip_pos_c_i, pos_d: flip_pos_d_i};
  assign busy = full;

  bfsts_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(start && !busy), .req_i(req),
    .full_o(full), .empty_o(empty), .pop_i(pop), .head_o(head)
  );

  bfsts_back #(.TableDepth(TABLE_DEPTH), .StateBits(STATE_BITS), .MaxFlips(MAX_FLIPS))
  u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .avail_i(!empty), .req_i(head), .pop_o(pop),
    .idle_o(idle), .entries_used_i(entries_used_q), .done_o(done_o),
    .found_position_o(found_position_o), .beyond_end_o(beyond_end_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !idle || empty || pop)
    else $error("result with engine state inconsistent");
endmodule
`default_nettype wire
